### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the path search block.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### rtl/core/gasp_pkg.sv
// Package for the grid path search: sizes, state encoding, function codes, square root and saturating add.
// Depends on nothing.
`default_nettype none
package gasp_pkg;
  localparam int GridRows = 8;
  localparam int GridCols = 8;
  localparam int CostFracBits = 8;
  localparam int CostW = 16;
  localparam logic [CostW-1:0] CostMax = 16'hFFFF;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_SCAN, ST_SCAN_END, ST_NB_RD, ST_NB_EVAL, ST_WALK_RD,
    ST_WALK_WAIT, ST_EMIT, ST_NOPATH
  } state_t;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  // Fixed-point square root of an integer (fb fraction bits) rounded to nearest, elaboration-time or table use only.
  function automatic logic [CostW-1:0] root_fixed(input int d2, input int fb);
    longint x;
    longint s;
    longint t;
    begin
      x = longint'(d2) << (2 * fb);
      s = 0;
      for (int b = 24; b >= 0; b--) begin
        t = s | (longint'(1) << b);
        if (t * t <= x) s = t;
      end
      if (x - s * s > s) s = s + 1;
      root_fixed = (s > 65535) ? CostMax : s[CostW-1:0];
    end
  endfunction

  function automatic logic [CostW-1:0] sat_add(input logic [CostW-1:0] a,
                                               input logic [CostW-1:0] b);
    logic [CostW:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      sat_add = s[CostW] ? CostMax : s[CostW-1:0];
    end
  endfunction
endpackage
`default_nettype wire

### rtl/core/gasp_ram.sv
// Generic single-port-write RAM with a registered read.
// Depends on nothing.
`default_nettype none
module gasp_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/core/grid_astar_path_search.sv
// Top level of the 8-connected grid path search.
// Depends on gasp_pkg, gasp_ram and assert_macros.svh.
//
// A word with func 0 writes one row of the occupancy grid at the accepting edge;
// busy stays low, so the next word may follow on the very next edge. A word with
// func 1 runs a best-first search from the source to the destination cell and
// answers with the path cells, source first, with last set on the destination, or
// with a single no-path word (status 1, cell 0, last 1). Result words leave one
// at a time, each on the ports for exactly one cycle under strobe; the receiver
// cannot stall them. busy stays high from the accepted search start until the
// last result has gone. A search first seeds the source, then runs expansions:
// each scans every cell slot through a single compare unit, closes the chosen
// cell, and handles each neighbour by reading the cost memories, then evaluating
// and writing back. The expansion that meets the destination stops at that
// neighbour. Tracing the path back reads the parent memory and then writes the
// path buffer for each parent step; sending reads each word from the path buffer
// and then drives it. An end point off the grid is answered with the no-path
// word, with no search.
// Cells are addressed internally as {row, col}, which keeps the scan in row-major
// order for any grid width. Per-search cost, parent and path stores are memories;
// the open marks and their "touched this search" bits are flip-flops, all cleared
// together when a search start is accepted, and an untouched entry reads as all
// ones.
`default_nettype none
`include "assert_macros.svh"
module grid_astar_path_search #(
  parameter int GridRows = gasp_pkg::GridRows,
  parameter int GridCols = gasp_pkg::GridCols,
  parameter int CostFracBits = gasp_pkg::CostFracBits
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       func,
  input  wire logic [2:0] row_index,
  input  wire logic [7:0] row_blocked,
  input  wire logic [2:0] src_row,
  input  wire logic [2:0] src_col,
  input  wire logic [2:0] dst_row,
  input  wire logic [2:0] dst_col,
  output logic            strobe,
  output logic [2:0]      cell_row,
  output logic [2:0]      cell_col,
  output logic            status,
  output logic            last
);
  // Cell slots, addressed as {row, col}.
  localparam int NCells = 64;
  localparam int CW = 6;
  localparam int CostW = gasp_pkg::CostW;
  localparam logic [CostW-1:0] StraightStep = CostW'(1 << CostFracBits);
  localparam logic [CostW-1:0] DiagStep = gasp_pkg::root_fixed(2, CostFracBits);

  gasp_pkg::state_t state, state_next;

  logic [7:0] blocked_map [8];
  logic [NCells-1:0] open_marks;
  logic [NCells-1:0] touched;
  logic [2:0] dr, dc;
  logic [CW-1:0] src, dst;
  logic [CW:0] scan_idx;
  logic [CW-1:0] cur;
  logic [2:0] cur_r, cur_c;
  logic cur_found;
  logic [CostW-1:0] cur_best;
  logic [CostW-1:0] cur_g;
  logic [2:0] dir;
  logic [CW-1:0] walk_cell;
  logic [CW:0] path_len;
  logic [CW:0] emit_idx;
  logic emit_rd;

  // Shared memories: best total, cost so far, parent, path buffer.
  logic bt_we, g_we, par_we, pb_we;
  logic [CW-1:0] bt_waddr, bt_raddr, g_raddr, par_waddr, par_raddr;
  logic [CostW-1:0] bt_wdata, bt_rdata, g_wdata, g_rdata;
  logic [CW-1:0] par_wdata, par_rdata;
  logic [CW-1:0] pb_waddr, pb_wdata, pb_rdata;

  gasp_ram #(.Width(CostW), .Depth(NCells)) u_best (
    .clk(clk), .we(bt_we), .waddr(bt_waddr), .wdata(bt_wdata),
    .raddr(bt_raddr), .rdata(bt_rdata));
  gasp_ram #(.Width(CostW), .Depth(NCells)) u_cost (
    .clk(clk), .we(g_we), .waddr(bt_waddr), .wdata(g_wdata),
    .raddr(g_raddr), .rdata(g_rdata));
  gasp_ram #(.Width(CW), .Depth(NCells)) u_parent (
    .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
    .raddr(par_raddr), .rdata(par_rdata));
  // Path cells, destination at index 0, source at the highest index.
  gasp_ram #(.Width(CW), .Depth(NCells)) u_path (
    .clk(clk), .we(pb_we), .waddr(pb_waddr), .wdata(pb_wdata),
    .raddr(emit_idx[CW-1:0]), .rdata(pb_rdata));

  // Heuristic table indexed by {row distance, column distance}.
  logic [CostW-1:0] heur_tab [NCells];
  for (genvar hi = 0; hi < NCells; hi++) begin : g_heur
    localparam logic [CostW-1:0] HeurVal =
      gasp_pkg::root_fixed((hi / 8) * (hi / 8) + (hi % 8) * (hi % 8), CostFracBits);
    assign heur_tab[hi] = HeurVal;
  end

  // Neighbour in the order N, S, E, W, NE, NW, SE, SW.
  logic signed [4:0] dro, dco, nr, nc;
  logic nb_in, nb_free, nb_diag;
  logic [CW-1:0] nb;
  logic [2:0] ar, ac;
  logic [CostW-1:0] nb_g, nb_f, nb_best, heur;
  logic [CW-1:0] scan_cell;
  logic scan_better;
  logic [CostW-1:0] scan_val;
  logic [CW-1:0] ptr_scan_d;
  logic scan_valid_d;

  always_comb begin
    dro = 5'sd0;
    dco = 5'sd0;
    case (dir)
      3'd0: begin dro = -5'sd1; dco = 5'sd0; end
      3'd1: begin dro = 5'sd1; dco = 5'sd0; end
      3'd2: begin dro = 5'sd0; dco = 5'sd1; end
      3'd3: begin dro = 5'sd0; dco = -5'sd1; end
      3'd4: begin dro = -5'sd1; dco = 5'sd1; end
      3'd5: begin dro = -5'sd1; dco = -5'sd1; end
      3'd6: begin dro = 5'sd1; dco = 5'sd1; end
      default: begin dro = 5'sd1; dco = -5'sd1; end
    endcase
    nr = $signed({2'b00, cur_r}) + dro;
    nc = $signed({2'b00, cur_c}) + dco;
    nb_in = (nr >= 0) && (nr < GridRows) && (nc >= 0) && (nc < GridCols);
    nb_free = nb_in && !blocked_map[nr[2:0]][nc[2:0]];
    nb = {nr[2:0], nc[2:0]};
    nb_diag = dir[2];
    ar = (nr[2:0] > dr) ? nr[2:0] - dr : dr - nr[2:0];
    ac = (nc[2:0] > dc) ? nc[2:0] - dc : dc - nc[2:0];
    heur = heur_tab[{ar, ac}];
    nb_g = gasp_pkg::sat_add(cur_g, nb_diag ? DiagStep : StraightStep);
    nb_f = gasp_pkg::sat_add(nb_g, heur);
    nb_best = touched[nb] ? bt_rdata : gasp_pkg::CostMax;
  end

  // Scan pipeline: address issued at scan_idx, data compared in the next cycle.
  assign scan_cell = scan_idx[CW-1:0];
  assign scan_val = touched[ptr_scan_d] ? bt_rdata : gasp_pkg::CostMax;
  assign scan_better = scan_valid_d && open_marks[ptr_scan_d] &&
                       (!cur_found || scan_val < cur_best);

  // Read address sharing.
  always_comb begin
    bt_raddr = scan_cell;
    g_raddr = cur;
    par_raddr = walk_cell;
    case (state)
      gasp_pkg::ST_NB_RD: bt_raddr = nb;
      // Point the cost read at the cell about to be expanded.
      gasp_pkg::ST_SCAN_END: g_raddr = scan_better ? ptr_scan_d : cur;
      default: bt_raddr = scan_cell;
    endcase
  end

  // Write port control.
  always_comb begin
    bt_we = 1'b0;
    g_we = 1'b0;
    par_we = 1'b0;
    pb_we = 1'b0;
    bt_waddr = nb;
    bt_wdata = nb_f;
    g_wdata = nb_g;
    par_waddr = nb;
    par_wdata = cur;
    pb_waddr = path_len[CW-1:0];
    pb_wdata = walk_cell;
    case (state)
      gasp_pkg::ST_INIT: begin
        bt_we = 1'b1;
        g_we = 1'b1;
        bt_waddr = src;
        bt_wdata = '0;
        g_wdata = '0;
        par_we = 1'b1;
        par_waddr = src;
        par_wdata = src;
        pb_we = 1'b1;
        pb_waddr = '0;
        pb_wdata = src;
      end
      gasp_pkg::ST_NB_EVAL: begin
        if (nb_free && nb == dst) begin
          par_we = 1'b1;
          pb_we = 1'b1;
          pb_waddr = '0;
          pb_wdata = dst;
        end else if (nb_free && nb_best > nb_f) begin
          bt_we = 1'b1;
          g_we = 1'b1;
          par_we = 1'b1;
        end
      end
      gasp_pkg::ST_WALK_WAIT: pb_we = 1'b1;
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      gasp_pkg::ST_IDLE:
        if (start && func == gasp_pkg::FUNC_SEARCH) begin
          if (src_row >= GridRows || src_col >= GridCols ||
              dst_row >= GridRows || dst_col >= GridCols)
            state_next = gasp_pkg::ST_NOPATH;
          else
            state_next = gasp_pkg::ST_INIT;
        end
      gasp_pkg::ST_INIT:
        state_next = (src == dst) ? gasp_pkg::ST_EMIT : gasp_pkg::ST_SCAN;
      gasp_pkg::ST_SCAN:
        if (scan_idx == (CW+1)'(NCells - 1)) state_next = gasp_pkg::ST_SCAN_END;
      gasp_pkg::ST_SCAN_END:
        state_next = (cur_found || scan_better) ? gasp_pkg::ST_NB_RD
                                                : gasp_pkg::ST_NOPATH;
      gasp_pkg::ST_NB_RD:
        state_next = gasp_pkg::ST_NB_EVAL;
      gasp_pkg::ST_NB_EVAL:
        if (nb_free && nb == dst) state_next = gasp_pkg::ST_WALK_RD;
        else if (dir == 3'd7) state_next = gasp_pkg::ST_SCAN;
        else state_next = gasp_pkg::ST_NB_RD;
      gasp_pkg::ST_WALK_RD:
        state_next = gasp_pkg::ST_WALK_WAIT;
      gasp_pkg::ST_WALK_WAIT:
        if (walk_cell == src || path_len == (CW+1)'(NCells - 1))
          state_next = gasp_pkg::ST_EMIT;
        else
          state_next = gasp_pkg::ST_WALK_RD;
      gasp_pkg::ST_EMIT:
        if (strobe && last) state_next = gasp_pkg::ST_IDLE;
      gasp_pkg::ST_NOPATH:
        if (strobe) state_next = gasp_pkg::ST_IDLE;
      default: state_next = gasp_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    busy = (state != gasp_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gasp_pkg::ST_IDLE;
      strobe <= 1'b0;
      for (int i = 0; i < 8; i++) blocked_map[i] <= '0;
      open_marks <= '0;
      touched <= '0;
      scan_valid_d <= 1'b0;
      cur_found <= 1'b0;
      emit_rd <= 1'b0;
    end else begin
      state <= state_next;
      strobe <= 1'b0;
      scan_valid_d <= 1'b0;
      case (state)
        gasp_pkg::ST_IDLE: begin
          if (start && func == gasp_pkg::FUNC_LOAD && row_index < GridRows)
            blocked_map[row_index] <= row_blocked;
          if (start && func == gasp_pkg::FUNC_SEARCH) begin
            dr <= dst_row;
            dc <= dst_col;
            src <= {src_row, src_col};
            dst <= {dst_row, dst_col};
            open_marks <= '0;
            touched <= '0;
          end
        end
        gasp_pkg::ST_INIT: begin
          open_marks[src] <= 1'b1;
          touched[src] <= 1'b1;
          scan_idx <= '0;
          cur_found <= 1'b0;
          path_len <= (CW+1)'(1);
          emit_idx <= '0;
        end
        gasp_pkg::ST_SCAN: begin
          if (scan_better) begin
            cur <= ptr_scan_d;
            cur_best <= scan_val;
            cur_found <= 1'b1;
          end
          ptr_scan_d <= scan_cell;
          scan_valid_d <= 1'b1;
          scan_idx <= scan_idx + 1'b1;
        end
        gasp_pkg::ST_SCAN_END: begin
          if (scan_better) begin
            cur <= ptr_scan_d;
            cur_r <= ptr_scan_d[5:3];
            cur_c <= ptr_scan_d[2:0];
            open_marks[ptr_scan_d] <= 1'b0;
          end else begin
            cur_r <= cur[5:3];
            cur_c <= cur[2:0];
            open_marks[cur] <= 1'b0;
          end
          dir <= '0;
          scan_idx <= '0;
          cur_found <= 1'b0;
        end
        gasp_pkg::ST_NB_RD: begin
          // cost memory holds g of the expanded cell at this read
          if (dir == 3'd0) cur_g <= g_rdata;
        end
        gasp_pkg::ST_NB_EVAL: begin
          if (nb_free && nb == dst) begin
            walk_cell <= cur;
            path_len <= (CW+1)'(1);
          end else if (nb_free && nb_best > nb_f) begin
            open_marks[nb] <= 1'b1;
            touched[nb] <= 1'b1;
          end
          dir <= dir + 1'b1;
        end
        gasp_pkg::ST_WALK_WAIT: begin
          path_len <= path_len + 1'b1;
          walk_cell <= par_rdata;
          if (state_next == gasp_pkg::ST_EMIT) emit_idx <= path_len;
        end
        gasp_pkg::ST_EMIT: begin
          // First settle the path read, then send the word.
          if (emit_rd) begin
            strobe <= 1'b1;
            cell_row <= pb_rdata[5:3];
            cell_col <= pb_rdata[2:0];
            status <= 1'b0;
            last <= (emit_idx == '0);
            emit_idx <= emit_idx - 1'b1;
            emit_rd <= 1'b0;
          end else if (!(strobe && last)) begin
            emit_rd <= 1'b1;
          end
        end
        gasp_pkg::ST_NOPATH: begin
          if (!strobe) begin
            strobe <= 1'b1;
            cell_row <= '0;
            cell_col <= '0;
            status <= 1'b1;
            last <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_IMPL(a_strobe_busy, clk, rst, strobe, busy, "result strobe while idle")
  `ASSERT_NEXT(a_strobe_pulse, clk, rst, strobe, !strobe, "result held over two cycles")
  `ASSERT_IMPL(a_nopath_last, clk, rst, strobe && status, last && cell_row == '0 && cell_col == '0, "no-path word malformed")
  `ASSERT_NEXT(a_last_idle, clk, rst, strobe && last, !busy, "busy after final word")
endmodule
`default_nettype wire
